### hdl/assert_macros.svh
// Assertion macros used by the converter's port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/ffsm_pkg.sv
// Package with kinds and constants of the float/fixed converter.
`timescale 1ns / 1ps
package ffsm_pkg;
  localparam int unsigned FracBitsDefault = 8;
  localparam logic [31:0] MagMax = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    KIND_F2X = 2'd0,
    KIND_I2X = 2'd1,
    KIND_X2F = 2'd2,
    KIND_X2I = 2'd3
  } kind_e;

  typedef struct packed {
    logic [31:0] result;
    logic        overflow;
  } res_t;
endpackage

### hdl/float_fixed_sign_magnitude_convert.sv
// Top level of the float/int/fixed sign-magnitude converter.
// Channel | Dir | tdata (low bit up)           | tuser
// s_axis  | in  | operand[31:0]                | kind[1:0]
// m_axis  | out | result[31:0]                 | overflow
// One word per cycle while tready is high; the result is registered before it is offered.
// The conversion sits between the input handshake and a result register,
// with a one-word skid stage in front of that register that takes one more word when the output
// stalls; tready is low while the skid word is held.
// Reset clears the valid flags only.
`timescale 1ns / 1ps
module float_fixed_sign_magnitude_convert #(
  parameter int unsigned FRAC_BITS = ffsm_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // operand[31:0]
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // result[31:0]
  output logic        m_axis_tuser_o    // overflow
);
  import ffsm_pkg::*;

  res_t core_res;
  res_t out_q, out_d, skid_q;
  logic out_vld_q, skid_vld_q;

  // Conversion logic.
  ffsm_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .kind_i(kind_e'(s_axis_tuser_i)),
    .operand_i(s_axis_tdata_i),
    .res_o(core_res)
  );

  assign s_axis_tready_o = !skid_vld_q;
  wire acc = s_axis_tvalid_i && s_axis_tready_o;
  wire pop = out_vld_q && m_axis_tready_i;

  assign out_d = skid_vld_q ? skid_q : core_res;

  // Output register with skid word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || pop) begin
        out_vld_q <= acc || skid_vld_q;
        skid_vld_q <= skid_vld_q && acc;
      end else if (acc) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      out_q <= out_d;
      if (skid_vld_q) skid_q <= core_res;
    end else if (acc) begin
      skid_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o = out_q.result;
  assign m_axis_tuser_o = out_q.overflow;
endmodule

### hdl/ffsm_core.sv
// Combinational conversion of one word for all four kinds.
`timescale 1ns / 1ps
module ffsm_core #(
  parameter int unsigned FRAC_BITS = ffsm_pkg::FracBitsDefault
) (
  input  ffsm_pkg::kind_e kind_i,
  input  logic [31:0]     operand_i,
  output ffsm_pkg::res_t  res_o
);
  import ffsm_pkg::*;

  localparam logic [8:0] FbW = 9'(FRAC_BITS);

  // Float to fixed.
  logic [31:0] f2x_r;
  logic        f2x_ov;
  logic [7:0]  fe;
  logic [23:0] fm;
  logic [9:0]  fs;  // shift ex - 23 + FRAC_BITS, signed
  logic [62:0] fsh;
  always_comb begin
    fe = operand_i[30:23];
    fm = (fe == 8'd0) ? {1'b0, operand_i[22:0]} : {1'b1, operand_i[22:0]};
    fs = (fe == 8'd0) ? (10'd0 - 10'd149 + 10'(FbW))
                      : (10'(fe) - 10'd150 + 10'(FbW));
    fsh = '0;
    f2x_ov = 1'b0;
    if (!fs[9]) begin
      if (fs > 10'd31) f2x_ov = 1'b1;
      else fsh = 63'(fm) << fs[4:0];
    end else if ((10'd0 - fs) < 10'd63) begin
      fsh = 63'(fm) >> (10'd0 - fs);
    end
    if (fsh > 63'(MagMax)) f2x_ov = 1'b1;
    if (fe == 8'hFF) f2x_ov = 1'b1;
    if (operand_i[30:0] == 31'd0) begin
      f2x_r = '0;
      f2x_ov = 1'b0;
    end else if (f2x_ov) begin
      f2x_r = {operand_i[31], MagMax[30:0]};
    end else begin
      f2x_r = {operand_i[31], fsh[30:0]};
    end
  end

  // Int to fixed.
  logic [31:0] i2x_r;
  logic        i2x_ov;
  logic [31:0] ia;
  logic [63:0] ish;
  always_comb begin
    ia = operand_i[31] ? (~operand_i + 32'd1) : operand_i;
    ish = 64'(ia) << FRAC_BITS;
    i2x_ov = (ish > 64'(MagMax));
    if (operand_i == 32'd0) i2x_r = '0;
    else if (i2x_ov) i2x_r = {operand_i[31], MagMax[30:0]};
    else i2x_r = {operand_i[31], ish[30:0]};
  end

  // Fixed to float, round to nearest even.
  logic [31:0] x2f_r;
  logic [30:0] mag;
  logic [4:0]  p;
  logic [4:0]  d;
  logic [30:0] rem;
  logic [30:0] half;
  logic [24:0] mant;
  logic [5:0]  pp;
  logic [7:0]  expo;
  always_comb begin
    mag = operand_i[30:0];
    p = '0;
    for (int i = 0; i < 31; i++) begin
      if (mag[i]) p = 5'(i);
    end
    d = '0;
    rem = '0;
    half = '0;
    pp = 6'(p);
    if (p <= 5'd23) begin
      mant = 25'(mag << (5'd23 - p));
    end else begin
      d = p - 5'd23;
      rem = mag & ((31'd1 << d) - 31'd1);
      half = 31'd1 << (d - 5'd1);
      mant = 25'(mag >> d);
      if (rem > half || (rem == half && mant[0])) mant = mant + 25'd1;
      if (mant[24]) begin
        mant = mant >> 1;
        pp = pp + 6'd1;
      end
    end
    expo = 8'(pp) - 8'(FbW) + 8'd127;
    if (mag == 31'd0) x2f_r = {operand_i[31], 31'd0};
    else x2f_r = {operand_i[31], expo, mant[22:0]};
  end

  // Fixed to int.
  logic [31:0] ip;
  always_comb begin
    ip = {1'b0, operand_i[30:0]} >> FRAC_BITS;
    if (operand_i[31]) ip = ~ip + 32'd1;
  end

  // Select by kind.
  always_comb begin
    unique case (kind_i)
      KIND_F2X: res_o = '{result: f2x_r, overflow: f2x_ov};
      KIND_I2X: res_o = '{result: i2x_r, overflow: i2x_ov};
      KIND_X2F: res_o = '{result: x2f_r, overflow: 1'b0};
      default:  res_o = '{result: ip, overflow: 1'b0};
    endcase
  end
endmodule

### hdl/ffsm_checker.sv
// Port checker for the converter, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);
  logic in_acc;
  logic out_stall;
  logic out_free;

  // Handshake terms used by the properties.
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_free = !m_axis_tvalid_o || m_axis_tready_i;

  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `ASSERT_NEXT(a_out, clk_i, rst_ni, in_acc, m_axis_tvalid_o)
  `ASSERT_NEXT(a_ready, clk_i, rst_ni, !m_axis_tvalid_o, s_axis_tready_o)
  `ASSERT_NEXT(a_ovk, clk_i, rst_ni, in_acc && s_axis_tuser_i[1] && out_free, !m_axis_tuser_o)
endmodule

bind float_fixed_sign_magnitude_convert ffsm_checker u_ffsm_checker (.*);

### bench/float_fixed_sign_magnitude_convert_check.sv
// Checker that predicts and compares the converter's result words.
`timescale 1ns / 1ps
module float_fixed_sign_magnitude_convert_check #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [31:0] s_axis_tdata_i,   // operand[31:0]
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,   // result[31:0]
  input  logic        m_axis_tuser_i,   // overflow
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);
  import ffsm_pkg::*;

  res_t conv_q[$];

  // Float bits to fixed word, truncating toward zero.
  function automatic res_t float_to_fixed(logic [31:0] x);
    res_t r;
    logic [7:0] e;
    logic [63:0] m;
    logic [63:0] mag;
    int ex;
    int s;
    r.overflow = 1'b0;
    e = x[30:23];
    if (x[30:0] == '0) begin
      r.result = '0;
      return r;
    end
    if (e == 8'hFF) begin
      r.result = {x[31], MagMax[30:0]};
      r.overflow = 1'b1;
      return r;
    end
    if (e == 0) begin
      m = {41'd0, x[22:0]};
      ex = -126;
    end else begin
      m = {40'd0, 1'b1, x[22:0]};
      ex = int'(e) - 127;
    end
    s = ex - 23 + int'(FRAC_BITS);
    if (s > 31) begin
      mag = 64'hFFFF_FFFF_FFFF;
    end else if (s >= 0) begin
      mag = m << s;
    end else if (-s >= 63) begin
      mag = '0;
    end else begin
      mag = m >> (-s);
    end
    if (mag > 64'(MagMax)) begin
      r.result = {x[31], MagMax[30:0]};
      r.overflow = 1'b1;
    end else begin
      r.result = {x[31], mag[30:0]};
    end
    return r;
  endfunction

  // Two's complement integer to fixed word.
  function automatic res_t int_to_fixed(logic [31:0] n);
    res_t r;
    logic [63:0] a;
    logic [63:0] mag;
    r.overflow = 1'b0;
    if (n == '0) begin
      r.result = '0;
      return r;
    end
    a = n[31] ? {32'd0, -n} : {32'd0, n};
    mag = a << FRAC_BITS;
    if (mag > 64'(MagMax)) begin
      r.result = {n[31], MagMax[30:0]};
      r.overflow = 1'b1;
    end else begin
      r.result = {n[31], mag[30:0]};
    end
    return r;
  endfunction

  // Fixed word to float bits, round to nearest even.
  function automatic res_t fixed_to_float(logic [31:0] w);
    res_t r;
    logic [31:0] mag;
    logic [31:0] mant;
    logic [31:0] rem;
    logic [31:0] half;
    logic [31:0] expo;
    int p;
    int d;
    r.overflow = 1'b0;
    mag = {1'b0, w[30:0]};
    if (mag == '0) begin
      r.result = {w[31], 31'd0};
      return r;
    end
    p = 0;
    for (int i = 0; i < 31; i++) begin
      if (mag[i]) p = i;
    end
    if (p <= 23) begin
      mant = mag << (23 - p);
    end else begin
      d = p - 23;
      rem = mag & ((32'd1 << d) - 1);
      half = 32'd1 << (d - 1);
      mant = mag >> d;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant[24]) begin
        mant = mant >> 1;
        p++;
      end
    end
    expo = 32'(p - int'(FRAC_BITS) + 127);
    r.result = {w[31], expo[7:0], mant[22:0]};
    return r;
  endfunction

  function automatic res_t predict_conversion(kind_e k, logic [31:0] op);
    res_t r;
    logic [31:0] ip;
    case (k)
      KIND_F2X: r = float_to_fixed(op);
      KIND_I2X: r = int_to_fixed(op);
      KIND_X2F: r = fixed_to_float(op);
      default: begin
        ip = {1'b0, op[30:0]} >> FRAC_BITS;
        r.result = op[31] ? -ip : ip;
        r.overflow = 1'b0;
      end
    endcase
    return r;
  endfunction

  assign pending_o = conv_q.size();

  // Queue predictions on input words, compare on output words.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      fail_count_o <= 0;
      result_count_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        conv_q.push_back(predict_conversion(kind_e'(s_axis_tuser_i), s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        result_count_o <= result_count_o + 1;
        if (conv_q.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: unexpected result word %h", m_axis_tdata_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = conv_q.pop_front();
          if (exp_r.result !== m_axis_tdata_i || exp_r.overflow !== m_axis_tuser_i) begin
            if (fail_count_o < 10) begin
              $display("ERROR: result exp %h/%b got %h/%b", exp_r.result, exp_r.overflow,
                       m_axis_tdata_i, m_axis_tuser_i);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

### bench/float_fixed_sign_magnitude_convert_test.sv
// Testbench top: clock, reset, stimulus and verdict for the converter.
`timescale 1ns / 1ps
module float_fixed_sign_magnitude_convert_test;
  import ffsm_pkg::*;

  localparam int NumRandom = 1350;
  localparam int IdleLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_count;
  int          pending;
  int          result_count;
  int          idle_cycles = 0;
  int          word_count = 0;

  always #6 clk_i = ~clk_i;

  float_fixed_sign_magnitude_convert u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid), .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i(s_axis_tdata), .s_axis_tuser_i(s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid), .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o(m_axis_tdata), .m_axis_tuser_o(m_axis_tuser)
  );

  float_fixed_sign_magnitude_convert_check #(.FRAC_BITS(FracBitsDefault)) u_check (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid), .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i(s_axis_tdata), .s_axis_tuser_i(s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid), .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i(m_axis_tdata), .m_axis_tuser_i(m_axis_tuser),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  // Random operand; float exponents are often clustered around the fixed range.
  function automatic logic [31:0] rand_operand(kind_e k);
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v[30:23] = 8'(111 + $urandom_range(0, 42));
      1: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: v = $urandom_range(0, 1) ? v >> $urandom_range(0, 31) : -(v >> $urandom_range(0, 31));
      default: ;
    endcase
    if (k == KIND_F2X && $urandom_range(0, 1)) v[30:23] = 8'(111 + $urandom_range(0, 42));
    return v;
  endfunction

  task automatic send_word(kind_e k, logic [31:0] op, bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= k;
    s_axis_tdata <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    word_count++;
  endtask

  // Receiver: random stalls, one long hold-off, then a no-stall stretch.
  initial begin
    int cyc;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc > 300 && cyc <= 400) m_axis_tready <= 1'b0;
      else if (cyc > 800 && cyc <= 1100) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 99) >= 28);
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] edge_ops[$];
    kind_e k;
    int n;
    edge_ops = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
                 32'h0000_0001, 32'h8000_0001, 32'h3F80_0000, 32'hBF80_0000, 32'h4EFF_FFFF,
                 32'h4B00_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h007F_FFFF, 32'h0000_00FF,
                 32'h0080_0000};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed extremes for every conversion kind.
    for (int i = 0; i < 4; i++) begin
      foreach (edge_ops[j]) begin
        if (j < 6 || i == 0) send_word(kind_e'(i), edge_ops[j], 1'b0);
      end
    end
    // Random mix; kept continuous during the long hold-off so the skid fills.
    for (n = 0; n < NumRandom; n++) begin
      k = kind_e'($urandom_range(0, 3));
      send_word(k, rand_operand(k), !(n >= 150 && n < 450));
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d words over all four kinds, checked %0d results.",
             word_count, result_count);
    $display("Stimulus included NaN, infinity, subnormals and saturating integers.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

### files.f
+incdir+hdl
hdl/ffsm_pkg.sv
hdl/ffsm_core.sv
hdl/float_fixed_sign_magnitude_convert.sv
hdl/ffsm_checker.sv
bench/float_fixed_sign_magnitude_convert_check.sv
bench/float_fixed_sign_magnitude_convert_test.sv
